[src/bm3_pkg.sv]
// Shared constants and types for the 3x3 binary morphology core.
package bm3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int MASK_W    = 9;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 11;

    localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRUCT_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    localparam logic [MASK_W-1:0] MASK_RESET = 9'h1FF;
    localparam int               SIZE_RESET = 1024;

    // per-beat control carried from the accept stage to the window stage
    typedef struct packed {
        logic is_pix;
        logic emit;
        logic top;
        logic bot;
        logic lft;
        logic rgt;
        logic last;
    } stage_ctl_t;

endpackage

[src/binary_morphology_3x3_core.sv]
// Streaming 3x3 binary erosion / dilation core with two line stores.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | s_valid s_ready s_req_type s_pixel_in | in
//  result  | m_valid m_ready m_pixel_out m_frame_last | out
//  config  | cfg_wr_en cfg_index cfg_wdata        | in
//
// One beat per clock unless the result stalls; after its last contributing
// beat is accepted, a result passes the accept then the result register.
// Line stores are read in the accept cycle, written in the window cycle.
// Reset is synchronous; line store contents are not cleared.
// A stalled result register holds the window stage, which holds s_ready low.
module binary_morphology_3x3_core
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [PIX_W-1:0]     s_pixel_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_pixel_out,
    output logic                 m_frame_last,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int HRW = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 3);
    localparam int W_RST = (SIZE_RESET > MAX_WIDTH)  ? MAX_WIDTH  : SIZE_RESET;
    localparam int H_RST = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

    // configuration
    logic              op_mode_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [WW-1:0]     w_reg;
    logic [HRW-1:0]    h_reg;
    logic [WW-1:0]     w_clamp;
    logic [HRW-1:0]    h_clamp;

    // counters
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;

    // accept stage
    logic             a_valid_reg;
    stage_ctl_t       a_ctl_reg;
    stage_ctl_t       ctl_next;
    logic [PIX_W-1:0] a_pix_reg;
    logic [AW-1:0]    a_col_reg;
    logic [PIX_W-1:0] rd_a_reg, rd_b_reg;
    logic             byp_reg;
    logic [PIX_W-1:0] byp_a_reg, byp_b_reg;

    // line stores
    logic [PIX_W-1:0] line_a_reg [MAX_WIDTH];
    logic [PIX_W-1:0] line_b_reg [MAX_WIDTH];

    // window and result
    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [PIX_W-1:0] v        [3][3];
    logic [PIX_W-1:0] top_px, mid_px;
    logic [PIX_W-1:0] res;
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_pix_reg;
    logic             m_last_reg;

    logic s_fire, a_fire, wr_en;
    logic input_done, is_pix, act, started, col_wrap, ocol_wrap, last;

    // ---------------- configuration ----------------
    always_comb begin
        if (cfg_wdata == '0) begin
            w_clamp = WW'(1);
        end else if (32'(cfg_wdata) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(cfg_wdata);
        end
        if (cfg_wdata == '0) begin
            h_clamp = HRW'(1);
        end else if (32'(cfg_wdata) > MAX_HEIGHT) begin
            h_clamp = HRW'(MAX_HEIGHT);
        end else begin
            h_clamp = HRW'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg <= MODE_ERODE;
            mask_reg    <= MASK_RESET;
            w_reg       <= WW'(W_RST);
            h_reg       <= HRW'(H_RST);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OP_MODE:      op_mode_reg <= cfg_wdata[0];
                REG_STRUCT_MASK:  mask_reg    <= cfg_wdata[MASK_W-1:0];
                REG_IMAGE_WIDTH:  w_reg       <= w_clamp;
                REG_IMAGE_HEIGHT: h_reg       <= h_clamp;
                default: ;
            endcase
        end
    end

    // ---------------- accept-side control ----------------
    assign a_fire  = a_valid_reg && (!a_ctl_reg.emit || !m_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || a_fire;
    assign s_fire  = s_valid && s_ready;

    assign input_done = 32'(in_row_reg) >= 32'(h_reg);
    assign is_pix     = (s_req_type == REQ_PIXEL) && !input_done;
    assign act        = is_pix || input_done;
    assign started    = (32'(in_row_reg) >= 2) || ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign col_wrap   = (32'(in_col_reg) + 1) == 32'(w_reg);
    assign ocol_wrap  = (32'(out_col_reg) + 1) == 32'(w_reg);
    assign last       = ocol_wrap && ((32'(out_row_reg) + 1) == 32'(h_reg));

    always_comb begin
        ctl_next.is_pix = is_pix;
        ctl_next.emit   = act && started;
        ctl_next.top    = out_row_reg == '0;
        ctl_next.bot    = (32'(out_row_reg) + 1) == 32'(h_reg);
        ctl_next.lft    = out_col_reg == '0;
        ctl_next.rgt    = ocol_wrap;
        ctl_next.last   = last;

        in_col_next  = col_wrap ? '0 : AW'(32'(in_col_reg) + 1);
        in_row_next  = col_wrap ? RW'(32'(in_row_reg) + 1) : in_row_reg;
        out_col_next = ocol_wrap ? '0 : AW'(32'(out_col_reg) + 1);
        out_row_next = ocol_wrap ? HW'(32'(out_row_reg) + 1) : out_row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (s_fire && act) begin
            if (ctl_next.emit && last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                in_col_reg <= in_col_next;
                in_row_reg <= in_row_next;
                if (ctl_next.emit) begin
                    out_col_reg <= out_col_next;
                    out_row_reg <= out_row_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_fire) begin
            a_valid_reg <= act;
        end else if (a_fire) begin
            a_valid_reg <= 1'b0;
        end
    end

    // payload and line store read; same-column write in this edge is bypassed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_ctl_reg <= ctl_next;
            a_pix_reg <= is_pix ? s_pixel_in : PIX_OFF;
            a_col_reg <= in_col_reg;
            rd_a_reg  <= line_a_reg[in_col_reg];
            rd_b_reg  <= line_b_reg[in_col_reg];
            byp_reg   <= wr_en && (a_col_reg == in_col_reg);
            byp_a_reg <= mid_px;
            byp_b_reg <= a_pix_reg;
        end
    end

    // ---------------- window stage ----------------
    assign wr_en  = a_fire && a_ctl_reg.is_pix;
    assign top_px = byp_reg ? byp_a_reg : rd_a_reg;
    assign mid_px = byp_reg ? byp_b_reg : rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_a_reg[a_col_reg] <= mid_px;
            line_b_reg[a_col_reg] <= a_pix_reg;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = top_px;
        win_next[1][2] = mid_px;
        win_next[2][2] = a_pix_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= PIX_OFF;
                end
            end
        end else if (a_fire) begin
            win_reg <= win_next;
        end
    end

    // zero padding at the frame edges, then the mask test
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && a_ctl_reg.top) || (r == 2 && a_ctl_reg.bot) ||
                    (c == 0 && a_ctl_reg.lft) || (c == 2 && a_ctl_reg.rgt)) begin
                    v[r][c] = PIX_OFF;
                end else begin
                    v[r][c] = win_next[r][c];
                end
            end
        end
        if (op_mode_reg == MODE_ERODE) begin
            res = PIX_ON;
            for (int k = 0; k < 9; k++) begin
                if (mask_reg[k] && v[k / 3][k % 3] == PIX_OFF) begin
                    res = PIX_OFF;
                end
            end
        end else begin
            res = v[1][1];
            if (v[1][1] == PIX_OFF) begin
                for (int k = 0; k < 9; k++) begin
                    if (mask_reg[k] && v[2 - k / 3][2 - k % 3] == PIX_ON) begin
                        res = PIX_ON;
                    end
                end
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_fire && a_ctl_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire && a_ctl_reg.emit) begin
            m_pix_reg  <= res;
            m_last_reg <= a_ctl_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pix_reg;
    assign m_frame_last = m_last_reg;

endmodule
